[rtl/assert_macros.svh]
// Assertion macros used by the keypad tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that expr holds at every clock edge outside reset.
`define KPD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("keypad debouncer assertion failed");

// Checks that cons holds in the cycle after ante.
`define KPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad debouncer assertion failed");

`else

`define KPD_ASSERT_ALWAYS(label, clk, rst, expr)
`define KPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/kpd_pkg.sv]
// Package with the types, constants and helpers of the keypad debouncer.
`default_nettype none

package kpd_pkg;

   localparam int LINE_BITS = 16;
   localparam int MAX_ROWS  = 16;
   localparam int MAX_COLS  = 16;
   localparam int IDX_W     = $clog2(LINE_BITS);
   localparam int CNT_W     = 5;
   localparam int TICK_W    = 16;

   localparam logic [IDX_W-1:0]  NO_LINE  = {IDX_W{1'b1}};
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_ROWS     = 2'd1;
   localparam logic [1:0] REG_COLS     = 2'd2;

   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [CNT_W-1:0]  ROWS_RESET     = 5'd16;
   localparam logic [CNT_W-1:0]  COLS_RESET     = 5'd16;

   localparam logic EVT_DOWN = 1'b0;
   localparam logic EVT_UP   = 1'b1;

   // Result of scanning one set of lines.
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } line_type;

   // One key position.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } pos_type;

   // One key event.
   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } event_type;

   // Limits a line count to the lines that exist.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] count,
                                                     input int limit);
      int n;
      n = int'(count);
      if (n > limit) n = limit;
      if (n > LINE_BITS) n = LINE_BITS;
      return CNT_W'(n);
   endfunction

endpackage

`default_nettype wire

[rtl/keypad_single_key_debouncer.sv]
// Top level of the single-key matrix keypad debouncer.
`default_nettype none

// Single-key keypad debouncer. Each req transaction is one scan tick with the
// sampled active-low row and column levels; only the lowest rows_in_use rows
// and cols_in_use columns count, and a key position is seen only when exactly
// one of them is low in each set. A position must persist for the configured
// debounce length in ticks (zero acts as one) before it becomes stable, and
// each change of the stable position produces one rsp transaction: key down,
// key up, or key down again when the key moves, with the old coordinates if a
// key was held before. The block takes one transaction per cycle unless an
// event waits on a stalled rsp channel, in which case the held tick waits and
// req stalls. Each tick is captured in an input register and, once the result
// register can take an event, updates the tracker state while any event it
// causes is written into the result register that drives rsp. The rate is set
// by the state update of the tracker. After reset no key is assumed pressed,
// and no clearing pass is needed. Registers on the configuration port: the
// debounce length at 0x0, rows_in_use at 0x4 and cols_in_use at 0x8; they are
// meant to be written only while the block is idle.
module keypad_single_key_debouncer (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [kpd_pkg::LINE_BITS-1:0] req_row_levels,
   input  wire logic [kpd_pkg::LINE_BITS-1:0] req_col_levels,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_event_kind,
   output logic [kpd_pkg::IDX_W-1:0]          rsp_key_row,
   output logic [kpd_pkg::IDX_W-1:0]          rsp_key_col,

   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [3:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   // Configuration registers.
   logic [kpd_pkg::TICK_W-1:0] debounce_ff;
   logic [kpd_pkg::CNT_W-1:0]  rows_ff;
   logic [kpd_pkg::CNT_W-1:0]  cols_ff;
   logic                       csr_write;
   logic [1:0]                 csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= kpd_pkg::DEBOUNCE_RESET;
         rows_ff     <= kpd_pkg::ROWS_RESET;
         cols_ff     <= kpd_pkg::COLS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            kpd_pkg::REG_DEBOUNCE: debounce_ff <= csr_pwdata[kpd_pkg::TICK_W-1:0];
            kpd_pkg::REG_ROWS:     rows_ff     <= csr_pwdata[kpd_pkg::CNT_W-1:0];
            kpd_pkg::REG_COLS:     cols_ff     <= csr_pwdata[kpd_pkg::CNT_W-1:0];
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         kpd_pkg::REG_DEBOUNCE: csr_prdata = {16'd0, debounce_ff};
         kpd_pkg::REG_ROWS:     csr_prdata = {27'd0, rows_ff};
         kpd_pkg::REG_COLS:     csr_prdata = {27'd0, cols_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // Input register. A held tick moves on whenever the result register can
   // take whatever it might produce.
   logic                          in_valid_ff, in_valid_in;
   logic [kpd_pkg::LINE_BITS-1:0] in_row_ff;
   logic [kpd_pkg::LINE_BITS-1:0] in_col_ff;
   logic                          req_take;
   logic                          advance;

   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_row_ff <= req_row_levels;
         in_col_ff <= req_col_levels;
      end
   end

   // Line scan and state update.
   kpd_pkg::line_type  row_line;
   kpd_pkg::line_type  col_line;
   kpd_pkg::event_type evt;
   logic               fire;

   kpd_line_decode u_row_decode (
      .levels (in_row_ff),
      .count  (kpd_pkg::clamp_count(rows_ff, kpd_pkg::MAX_ROWS)),
      .line   (row_line)
   );

   kpd_line_decode u_col_decode (
      .levels (in_col_ff),
      .count  (kpd_pkg::clamp_count(cols_ff, kpd_pkg::MAX_COLS)),
      .line   (col_line)
   );

   kpd_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .row_line   (row_line),
      .col_line   (col_line),
      .hold_limit (debounce_ff),
      .fire       (fire),
      .evt        (evt)
   );

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   kpd_pkg::event_type rsp_evt_ff;

   always_comb begin
      if (advance && fire) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fire) begin
         rsp_evt_ff <= evt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_evt_ff.kind;
   assign rsp_key_row    = rsp_evt_ff.row;
   assign rsp_key_col    = rsp_evt_ff.col;

endmodule

`default_nettype wire

[rtl/kpd_line_decode.sv]
// Finds the single active-low line among the scanned lines.
`default_nettype none

module kpd_line_decode (
   input  wire logic [kpd_pkg::LINE_BITS-1:0] levels,
   input  wire logic [kpd_pkg::CNT_W-1:0]     count,
   output kpd_pkg::line_type                  line
);

   logic [kpd_pkg::LINE_BITS-1:0] mask;
   logic [kpd_pkg::LINE_BITS-1:0] act;
   logic [kpd_pkg::IDX_W-1:0]     idx;
   logic                          hit;

   always_comb begin
      for (int i = 0; i < kpd_pkg::LINE_BITS; i++) begin
         mask[i] = (i < int'(count));
      end
   end

   assign act = ~levels & mask;

   // With a single bit set, ORing the positions of set bits gives its index.
   always_comb begin
      idx = '0;
      for (int i = 0; i < kpd_pkg::LINE_BITS; i++) begin
         if (act[i]) idx = idx | kpd_pkg::IDX_W'(i);
      end
   end

   assign hit  = (act != '0) &&
                 ((act & (act - kpd_pkg::LINE_BITS'(1))) == '0);
   assign line = '{hit: hit, idx: idx};

endmodule

`default_nettype wire

[rtl/kpd_tracker.sv]
// Pending and stable key state with the debounce count and event decision.
`default_nettype none

`include "assert_macros.svh"

module kpd_tracker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire kpd_pkg::line_type          row_line,
   input  wire kpd_pkg::line_type          col_line,
   input  wire logic [kpd_pkg::TICK_W-1:0] hold_limit,
   output logic                            fire,
   output kpd_pkg::event_type              evt
);

   kpd_pkg::pos_type            cur;
   kpd_pkg::pos_type            pending_ff, pending_in;
   kpd_pkg::pos_type            stable_ff, stable_in;
   logic [kpd_pkg::TICK_W-1:0]  ticks_ff, ticks_in;
   logic [kpd_pkg::TICK_W-1:0]  need;
   logic                        changed;

   always_comb begin
      cur.valid = row_line.hit && col_line.hit;
      cur.row   = cur.valid ? row_line.idx : kpd_pkg::NO_LINE;
      cur.col   = cur.valid ? col_line.idx : kpd_pkg::NO_LINE;
   end

   assign changed    = (cur != pending_ff);
   assign pending_in = changed ? cur : pending_ff;

   always_comb begin
      if (changed) ticks_in = '0;
      else if (ticks_ff != kpd_pkg::TICK_MAX) ticks_in = ticks_ff + kpd_pkg::TICK_W'(1);
      else ticks_in = ticks_ff;
   end

   // A zero debounce count behaves as one tick.
   assign need = (hold_limit == '0) ? kpd_pkg::TICK_W'(1) : hold_limit;
   assign fire = (pending_in != stable_ff) && (ticks_in >= need);

   always_comb begin
      evt.kind = (stable_ff.valid && !pending_in.valid) ? kpd_pkg::EVT_UP
                                                        : kpd_pkg::EVT_DOWN;
      evt.row  = stable_ff.valid ? stable_ff.row : pending_in.row;
      evt.col  = stable_ff.valid ? stable_ff.col : pending_in.col;
   end

   assign stable_in = fire ? pending_in : stable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '{valid: 1'b0, row: kpd_pkg::NO_LINE, col: kpd_pkg::NO_LINE};
         stable_ff  <= '{valid: 1'b0, row: kpd_pkg::NO_LINE, col: kpd_pkg::NO_LINE};
         ticks_ff   <= '0;
      end else if (advance) begin
         pending_ff <= pending_in;
         stable_ff  <= stable_in;
         ticks_ff   <= ticks_in;
      end
   end

   `KPD_ASSERT_ALWAYS(a_stable_idle_coords, clock, reset,
      stable_ff.valid || (stable_ff.row == kpd_pkg::NO_LINE && stable_ff.col == kpd_pkg::NO_LINE))
   `KPD_ASSERT_NEXT(a_fire_takes_pending, clock, reset, advance && fire,
      stable_ff == pending_ff)
   `KPD_ASSERT_NEXT(a_change_restarts_count, clock, reset, advance && changed,
      ticks_ff == '0)

endmodule

`default_nettype wire
